FILE: hdl/imucf_pkg.sv
// Shared constants, types and helper functions for the IMU attitude filter.
`default_nettype none

package imucf_pkg;

    // CORDIC datapath: 40 bits covers the gain-scaled magnitude of both passes
    localparam int CW        = 40;
    localparam int AW        = 32;
    localparam int TABLE_LEN = 24;
    localparam int IW        = $clog2(TABLE_LEN);

    // Multiply-accumulate operand and result widths
    localparam int MA_W = 18;
    localparam int MB_W = 33;
    localparam int MR_W = 52;

    localparam logic signed [AW-1:0]   DEG180_Q16  = 32'sd11796480;
    localparam logic signed [MB_W-1:0] NEG_GAIN_Q16 = -33'sd107922;
    localparam logic [15:0]            ALPHA_RESET = 16'd64225;
    localparam logic [16:0]            ALPHA_ONE   = 17'h10000;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_stat;

    // atan(2^-i) in Q15.16 degrees
    function automatic logic signed [AW-1:0] atan_deg_q16(input logic [IW-1:0] idx);
        logic signed [AW-1:0] v;
        case (idx)
            5'd0:    v = 32'sd2949120;
            5'd1:    v = 32'sd1740967;
            5'd2:    v = 32'sd919879;
            5'd3:    v = 32'sd466945;
            5'd4:    v = 32'sd234379;
            5'd5:    v = 32'sd117304;
            5'd6:    v = 32'sd58666;
            5'd7:    v = 32'sd29335;
            5'd8:    v = 32'sd14668;
            5'd9:    v = 32'sd7334;
            5'd10:   v = 32'sd3667;
            5'd11:   v = 32'sd1833;
            5'd12:   v = 32'sd917;
            5'd13:   v = 32'sd458;
            5'd14:   v = 32'sd229;
            5'd15:   v = 32'sd115;
            5'd16:   v = 32'sd57;
            5'd17:   v = 32'sd29;
            5'd18:   v = 32'sd14;
            5'd19:   v = 32'sd7;
            5'd20:   v = 32'sd4;
            5'd21:   v = 32'sd2;
            5'd22:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [AW-1:0] sat32(input logic signed [MR_W-1:0] v);
        logic signed [AW-1:0] r;
        if (v[MR_W-1:AW-1] == '0 || v[MR_W-1:AW-1] == '1) begin
            r = v[AW-1:0];
        end else if (v[MR_W-1]) begin
            r = {1'b1, {(AW-1){1'b0}}};
        end else begin
            r = {1'b0, {(AW-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/imucf_cordic.sv
// Iterative CORDIC vectoring engine: one micro-rotation per clock.
`default_nettype none

module imucf_cordic #(
    parameter int STEPS = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_start,
    input  wire  signed [imucf_pkg::CW-1:0]       i_x,
    input  wire  signed [imucf_pkg::CW-1:0]       i_y,
    output logic signed [imucf_pkg::AW-1:0]       o_angle,
    output logic signed [imucf_pkg::CW-1:0]       o_mag,
    output imucf_pkg::t_cordic_stat               o_stat
);

    localparam logic [imucf_pkg::IW-1:0] LAST = imucf_pkg::IW'(STEPS - 1);

    logic signed [imucf_pkg::CW-1:0] r_x, r_y, n_x, n_y;
    logic signed [imucf_pkg::AW-1:0] r_z, n_z;
    logic [imucf_pkg::IW-1:0]        r_i;
    logic                            r_busy, r_done;
    logic signed [imucf_pkg::CW-1:0] w_xs, w_ys;
    logic signed [imucf_pkg::AW-1:0] w_atan;

    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_atan = imucf_pkg::atan_deg_q16(r_i);

    always_comb begin
        if (i_start) begin
            if (i_x == '0 && i_y == '0) begin
                n_x = '0;
                n_y = '0;
                n_z = '0;
            end else if (i_x < 0) begin
                // pre-rotate by half a turn
                n_x = -i_x;
                n_y = -i_y;
                n_z = (i_y >= 0) ? imucf_pkg::DEG180_Q16 : -imucf_pkg::DEG180_Q16;
            end else begin
                n_x = i_x;
                n_y = i_y;
                n_z = '0;
            end
        end else if (r_busy) begin
            if (!r_y[imucf_pkg::CW-1]) begin
                n_x = r_x + w_ys;
                n_y = r_y - w_xs;
                n_z = r_z + w_atan;
            end else begin
                n_x = r_x - w_ys;
                n_y = r_y + w_xs;
                n_z = r_z - w_atan;
            end
        end else begin
            n_x = r_x;
            n_y = r_y;
            n_z = r_z;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_i <= '0;
            if (i_x == '0 && i_y == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end
        end else if (r_busy) begin
            if (r_i == LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_i <= r_i + 1'b1;
            end
        end
    end

    assign o_angle = r_z;
    assign o_mag   = r_x;

    always_comb begin
        o_stat.busy = r_busy;
        o_stat.done = r_done;
    end

endmodule

`default_nettype wire

FILE: hdl/imucf_mac.sv
// Shared multiply-add unit with registered result.
`default_nettype none

module imucf_mac (
    input  wire                                i_clk,
    input  wire  signed [imucf_pkg::MA_W-1:0]  i_mul_a,
    input  wire  signed [imucf_pkg::MB_W-1:0]  i_mul_b,
    input  wire  signed [imucf_pkg::MR_W-1:0]  i_add,
    output logic signed [imucf_pkg::MR_W-1:0]  o_res
);

    localparam int PW = imucf_pkg::MA_W + imucf_pkg::MB_W;

    logic signed [PW-1:0]              w_prod;
    logic signed [imucf_pkg::MR_W-1:0] r_res;

    assign w_prod = i_mul_a * i_mul_b;

    always_ff @(posedge i_clk) begin
        r_res <= {{(imucf_pkg::MR_W-PW){w_prod[PW-1]}}, w_prod} + i_add;
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

FILE: hdl/imu_complementary_attitude_filter.sv
// Top level: IMU complementary attitude filter with sequencer and shared units.
`default_nettype none

// Channel      | Direction | Payload                                   | Handshake
// -------------+-----------+-------------------------------------------+------------------------
// s_axis       | in        | accel xyz, gyro rate xyz, elapsed time    | s_axis_tvalid/tready
// m_axis       | out       | roll, pitch, yaw (Q15.16 degrees)         | m_axis_tvalid/tready
// cfg          | in        | blend alpha (Q0.16 gyro weight)           | i_cfg_valid/o_cfg_ready
//
// The time a sample takes is set by the two back-to-back passes through the single
// CORDIC engine; the gain product, the three integrations and the two blends share one
// multiply-add unit. The integrations overlap the first pass and the roll blend the second;
// the gain product comes before the first pass and the pitch blend follows the second.
// s_axis_tready is high only while the sequencer is idle. A finished result sits in an
// output register, so the next sample can start while m_axis is stalled.
// Reset (synchronous, active low) zeroes the angle estimates and loads alpha 64225.

module imu_complementary_attitude_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // cfg write channel
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [15:0]  i_cfg_data,    // blend_alpha
    // sample stream in
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [111:0] s_axis_tdata,  // accel_x, accel_y, accel_z, rate_x, rate_y,
                                        // rate_z, elapsed_time (16 bits each, low first)
    // attitude stream out
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [95:0]  m_axis_tdata   // roll_angle, pitch_angle, yaw_angle (32 bits each)
);

    localparam int CW   = imucf_pkg::CW;
    localparam int AW   = imucf_pkg::AW;
    localparam int MA_W = imucf_pkg::MA_W;
    localparam int MB_W = imucf_pkg::MB_W;
    localparam int MR_W = imucf_pkg::MR_W;

    typedef enum logic [12:0] {
        S_IDLE       = 13'b0000000000001,
        S_GAIN       = 13'b0000000000010,
        S_ROLL_GO    = 13'b0000000000100,
        S_INT_Y      = 13'b0000000001000,
        S_INT_Z      = 13'b0000000010000,
        S_ROLL_WAIT  = 13'b0000000100000,
        S_PITCH_GO   = 13'b0000001000000,
        S_BLEND_R2   = 13'b0000010000000,
        S_PITCH_WAIT = 13'b0000100000000,
        S_BLEND_P1   = 13'b0001000000000,
        S_BLEND_P2   = 13'b0010000000000,
        S_WB         = 13'b0100000000000,
        S_DONE       = 13'b1000000000000
    } t_state;

    // where the registered multiply-add result goes, in the cycle after issue
    typedef enum logic [2:0] {
        WB_NONE,
        WB_PITCH_Y,
        WB_ROLL_I,
        WB_PITCH_I,
        WB_YAW_I,
        WB_ROLL_B,
        WB_PITCH_B
    } t_wb;

    t_state r_state, n_state;
    t_wb    r_wb, n_wb;

    // latched sample
    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy, r_gz;
    logic        [15:0] r_et;

    // filter state and config
    logic signed [AW-1:0] r_roll, r_pitch, r_yaw;
    logic        [15:0]   r_alpha;

    // intermediates
    logic signed [CW-1:0] r_pitch_y;
    logic signed [AW-1:0] r_acc_roll;

    // output register
    logic        r_out_valid;
    logic [95:0] r_out_data;

    // shared units
    logic signed [MA_W-1:0]   w_mul_a;
    logic signed [MB_W-1:0]   w_mul_b;
    logic signed [MR_W-1:0]   w_add, w_res, w_sh8, w_sh16;
    logic                     w_cstart;
    logic signed [CW-1:0]     w_cx, w_cy, w_cmag;
    logic signed [AW-1:0]     w_cangle;
    imucf_pkg::t_cordic_stat  w_cstat;

    logic w_in_acc, w_load;
    logic signed [MA_W-1:0] w_alpha_a, w_beta_a;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_load        = !r_out_valid || m_axis_tready;

    assign w_alpha_a = {2'b00, r_alpha};
    assign w_beta_a  = {1'b0, imucf_pkg::ALPHA_ONE - {1'b0, r_alpha}};

    // integration addend: estimate scaled by 2^8, plus half an LSB for rounding
    function automatic logic signed [MR_W-1:0] int_addend(input logic signed [AW-1:0] est);
        return {{(MR_W-AW-8){est[AW-1]}}, est, 8'h80};
    endfunction

    function automatic logic signed [MB_W-1:0] sx33(input logic signed [AW-1:0] v);
        return {v[AW-1], v};
    endfunction

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:       if (w_in_acc) n_state = S_GAIN;
            S_GAIN:       n_state = S_ROLL_GO;
            S_ROLL_GO:    n_state = S_INT_Y;
            S_INT_Y:      n_state = S_INT_Z;
            S_INT_Z:      n_state = S_ROLL_WAIT;
            S_ROLL_WAIT:  if (w_cstat.done) n_state = S_PITCH_GO;
            S_PITCH_GO:   n_state = S_BLEND_R2;
            S_BLEND_R2:   n_state = S_PITCH_WAIT;
            S_PITCH_WAIT: if (w_cstat.done) n_state = S_BLEND_P1;
            S_BLEND_P1:   n_state = S_BLEND_P2;
            S_BLEND_P2:   n_state = S_WB;
            S_WB:         n_state = S_DONE;
            S_DONE:       if (w_load) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // ---------------- multiply-add operand selection ----------------
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        w_add   = '0;
        n_wb    = WB_NONE;
        case (r_state)
            S_GAIN: begin
                // -accel_x * gain
                w_mul_a = {{2{r_ax[15]}}, r_ax};
                w_mul_b = imucf_pkg::NEG_GAIN_Q16;
                n_wb    = WB_PITCH_Y;
            end
            S_ROLL_GO: begin
                w_mul_a = {{2{r_gx[15]}}, r_gx};
                w_mul_b = {17'd0, r_et};
                w_add   = int_addend(r_roll);
                n_wb    = WB_ROLL_I;
            end
            S_INT_Y: begin
                w_mul_a = {{2{r_gy[15]}}, r_gy};
                w_mul_b = {17'd0, r_et};
                w_add   = int_addend(r_pitch);
                n_wb    = WB_PITCH_I;
            end
            S_INT_Z: begin
                w_mul_a = {{2{r_gz[15]}}, r_gz};
                w_mul_b = {17'd0, r_et};
                w_add   = int_addend(r_yaw);
                n_wb    = WB_YAW_I;
            end
            S_PITCH_GO: begin
                w_mul_a = w_alpha_a;
                w_mul_b = sx33(r_roll);
                w_add   = MR_W'(32768);
            end
            S_BLEND_R2: begin
                w_mul_a = w_beta_a;
                w_mul_b = sx33(r_acc_roll);
                w_add   = w_res;
                n_wb    = WB_ROLL_B;
            end
            S_BLEND_P1: begin
                w_mul_a = w_alpha_a;
                w_mul_b = sx33(r_pitch);
                w_add   = MR_W'(32768);
            end
            S_BLEND_P2: begin
                w_mul_a = w_beta_a;
                w_mul_b = sx33(w_cangle);
                w_add   = w_res;
                n_wb    = WB_PITCH_B;
            end
            default: begin
                n_wb = WB_NONE;
            end
        endcase
    end

    // ---------------- CORDIC operand selection ----------------
    assign w_cstart = (r_state == S_ROLL_GO) || (r_state == S_PITCH_GO);

    always_comb begin
        if (r_state == S_PITCH_GO) begin
            // second pass: gain-scaled magnitude against scaled -accel_x
            w_cx = w_cmag;
            w_cy = r_pitch_y;
        end else begin
            w_cx = {{(CW-32){r_az[15]}}, r_az, 16'd0};
            w_cy = {{(CW-32){r_ay[15]}}, r_ay, 16'd0};
        end
    end

    imucf_mac u_mac (
        .i_clk   (i_clk),
        .i_mul_a (w_mul_a),
        .i_mul_b (w_mul_b),
        .i_add   (w_add),
        .o_res   (w_res)
    );

    imucf_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_x     (w_cx),
        .i_y     (w_cy),
        .o_angle (w_cangle),
        .o_mag   (w_cmag),
        .o_stat  (w_cstat)
    );

    assign w_sh8  = w_res >>> 8;
    assign w_sh16 = w_res >>> 16;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wb        <= WB_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wb    <= n_wb;
            if (r_state == S_DONE && w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- filter state and config ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll  <= '0;
            r_pitch <= '0;
            r_yaw   <= '0;
            r_alpha <= imucf_pkg::ALPHA_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_alpha <= i_cfg_data;
            end
            case (r_wb)
                WB_ROLL_I:  r_roll  <= imucf_pkg::sat32(w_sh8);
                WB_PITCH_I: r_pitch <= imucf_pkg::sat32(w_sh8);
                WB_YAW_I:   r_yaw   <= imucf_pkg::sat32(w_sh8);
                WB_ROLL_B:  r_roll  <= imucf_pkg::sat32(w_sh16);
                WB_PITCH_B: r_pitch <= imucf_pkg::sat32(w_sh16);
                default:    ;
            endcase
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ax <= s_axis_tdata[15:0];
            r_ay <= s_axis_tdata[31:16];
            r_az <= s_axis_tdata[47:32];
            r_gx <= s_axis_tdata[63:48];
            r_gy <= s_axis_tdata[79:64];
            r_gz <= s_axis_tdata[95:80];
            r_et <= s_axis_tdata[111:96];
        end
        if (r_wb == WB_PITCH_Y) begin
            r_pitch_y <= w_res[CW-1:0];
        end
        if (r_state == S_ROLL_WAIT && w_cstat.done) begin
            r_acc_roll <= w_cangle;
        end
        if (r_state == S_DONE && w_load) begin
            r_out_data <= {r_yaw, r_pitch, r_roll};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTH
    // a new CORDIC pass never lands on one still running
    a_cordic_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cstart |-> !w_cstat.busy)
        else $error("CORDIC started while busy");

    // second blend step must directly follow the first for the feedback add
    a_blend_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLEND_R2) |-> ($past(r_state) == S_PITCH_GO))
        else $error("roll blend steps out of order");

    // estimates are settled when the result is loaded
    a_wb_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_wb == WB_NONE))
        else $error("result loaded with a writeback pending");
`endif

endmodule

`default_nettype wire
